// File: hdl/sdcd_pkg.sv
package sdcd_pkg;

   localparam int unsigned BASE_YEAR    = 1900;
   localparam int unsigned YEAR_W       = 12;
   localparam int unsigned MONTH_W      = 4;
   localparam int unsigned DOM_W        = 5;
   localparam int unsigned COMMON_DAYS  = 365;
   localparam int unsigned LEAP_DAYS    = 366;

   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

   // position of 1900 within the 4, 100 and 400 year cycles
   localparam logic [1:0] BASE_MOD4   = 2'd0;
   localparam logic [6:0] BASE_MOD100 = 7'd0;
   localparam logic [8:0] BASE_MOD400 = 9'd300;
   localparam logic [6:0] MOD100_LAST = 7'd99;
   localparam logic [8:0] MOD400_LAST = 9'd399;

   function automatic logic [DOM_W-1:0] month_days(input logic [MONTH_W-1:0] mo,
                                                   input logic              leap);
      logic [DOM_W-1:0] d;
      case (mo)
         4'd1:    d = 5'd31;
         4'd2:    d = leap ? 5'd29 : 5'd28;
         4'd3:    d = 5'd31;
         4'd4:    d = 5'd30;
         4'd5:    d = 5'd31;
         4'd6:    d = 5'd30;
         4'd7:    d = 5'd31;
         4'd8:    d = 5'd31;
         4'd9:    d = 5'd30;
         4'd10:   d = 5'd31;
         4'd11:   d = 5'd30;
         4'd12:   d = 5'd31;
         default: d = 5'd31;
      endcase
      return d;
   endfunction

endpackage

// File: hdl/serial_day_to_calendar_date_top.sv
// Channel   Ports                                        Handshake
// request   req_day_number                               start high, busy low
// response  rsp_year, rsp_month, rsp_day_of_month        rsp_valid, one cycle
//
// Each word passes through year steps, an exit from the year loop, month steps and a
// finishing step, all on a single subtractor: one subtract per year passed (up to about
// 360 years at 17 bits), then one subtract per month passed (up to 11 months).
// busy stays high through the finishing step and is low while the result is shown,
// so a new word may start then. Synchronous reset returns to idle. The receiver cannot stall.
module serial_day_to_calendar_date_top
   import sdcd_pkg::*;
#(
   parameter int unsigned DAY_BITS = 17
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [DAY_BITS-1:0] req_day_number,
   output logic                rsp_valid,
   output logic [YEAR_W-1:0]   rsp_year,
   output logic [MONTH_W-1:0]  rsp_month,
   output logic [DOM_W-1:0]    rsp_day_of_month
);

   localparam int unsigned YEAR_SPAN = $clog2(BASE_YEAR + (2**DAY_BITS) / COMMON_DAYS + 2);
   localparam int unsigned YEAR_BITS = (YEAR_SPAN > YEAR_W) ? YEAR_SPAN : YEAR_W;

   typedef enum logic [1:0] {ST_IDLE, ST_YEARS, ST_MONTHS} state_type;

   state_type              state_ff, state_in;
   logic [DAY_BITS-1:0]    left_ff, left_in;
   logic [YEAR_BITS-1:0]   year_ff, year_in;
   logic [MONTH_W-1:0]     month_ff, month_in;
   logic [1:0]             mod4_ff, mod4_in;
   logic [6:0]             mod100_ff, mod100_in;
   logic [8:0]             mod400_ff, mod400_in;
   logic                   valid_ff, valid_in;
   logic [YEAR_W-1:0]      oyear_ff, oyear_in;
   logic [MONTH_W-1:0]     omonth_ff, omonth_in;
   logic [DOM_W-1:0]       odom_ff, odom_in;

   logic                   leap;
   logic [DAY_BITS-1:0]    step;
   logic [DAY_BITS-1:0]    diff;
   logic                   more;

   assign leap = ((mod4_ff == 2'd0) && (mod100_ff != 7'd0)) || (mod400_ff == 9'd0);

   always_comb begin
      if (state_ff == ST_YEARS) begin
         step = leap ? DAY_BITS'(LEAP_DAYS) : DAY_BITS'(COMMON_DAYS);
      end else begin
         step = DAY_BITS'(month_days(month_ff, leap));
      end
   end

   assign diff = left_ff - step;
   assign more = left_ff > step;

   always_comb begin
      state_in  = state_ff;
      left_in   = left_ff;
      year_in   = year_ff;
      month_in  = month_ff;
      mod4_in   = mod4_ff;
      mod100_in = mod100_ff;
      mod400_in = mod400_ff;
      valid_in  = 1'b0;
      oyear_in  = oyear_ff;
      omonth_in = omonth_ff;
      odom_in   = odom_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               left_in   = req_day_number;
               year_in   = YEAR_BITS'(BASE_YEAR);
               month_in  = MONTH_JAN;
               mod4_in   = BASE_MOD4;
               mod100_in = BASE_MOD100;
               mod400_in = BASE_MOD400;
               state_in  = ST_YEARS;
            end
         end
         ST_YEARS: begin
            // a leap year with exactly its length left stays put
            if (left_ff > DAY_BITS'(COMMON_DAYS) &&
                !(leap && left_ff == DAY_BITS'(LEAP_DAYS))) begin
               left_in   = diff;
               year_in   = year_ff + 1'b1;
               mod4_in   = mod4_ff + 1'b1;
               mod100_in = (mod100_ff == MOD100_LAST) ? 7'd0 : mod100_ff + 1'b1;
               mod400_in = (mod400_ff == MOD400_LAST) ? 9'd0 : mod400_ff + 1'b1;
            end else begin
               state_in = ST_MONTHS;
            end
         end
         ST_MONTHS: begin
            if (month_ff < MONTH_DEC && more) begin
               left_in  = diff;
               month_in = month_ff + 1'b1;
            end else begin
               valid_in  = 1'b1;
               oyear_in  = year_ff[YEAR_W-1:0];
               omonth_in = month_ff;
               odom_in   = left_ff[DOM_W-1:0];
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      left_ff   <= left_in;
      year_ff   <= year_in;
      month_ff  <= month_in;
      mod4_ff   <= mod4_in;
      mod100_ff <= mod100_in;
      mod400_ff <= mod400_in;
      oyear_ff  <= oyear_in;
      omonth_ff <= omonth_in;
      odom_ff   <= odom_in;
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = valid_ff;
   assign rsp_year         = oyear_ff;
   assign rsp_month        = omonth_ff;
   assign rsp_day_of_month = odom_ff;

endmodule

// File: hdl/sdcd_checker.sv
module sdcd_checker
   import sdcd_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic                rsp_valid,
   input logic [YEAR_W-1:0]   rsp_year,
   input logic [MONTH_W-1:0]  rsp_month,
   input logic [DOM_W-1:0]    rsp_day_of_month
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy && !rsp_valid)
      else $error("accepted word did not raise busy");

   a_result_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while busy");

   a_strobe_once: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held over two cycles");

   a_date_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_month >= MONTH_JAN) && (rsp_month <= MONTH_DEC) &&
                    ((rsp_day_of_month != '0) ||
                     ((rsp_month == MONTH_JAN) && (rsp_year == YEAR_W'(BASE_YEAR)))))
      else $error("date out of range");

   a_result_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(busy))
      else $error("result without a word in flight");

endmodule

bind serial_day_to_calendar_date_top sdcd_checker u_sdcd_checker (.*);
